FILE: sv/rpa_pkg.sv
// Shared types, codes and default sizes for the reference-counted page allocator.
// Used by every module of the block and by its checker; depends on nothing.
`default_nettype none

package rpa_pkg;

  // Default sizes handed to the top level parameters.
  localparam int PAGE_SHIFT_DEF = 12;
  localparam int MAX_PAGES_DEF  = 65536;
  localparam int COUNT_BITS_DEF = 16;

  // Fixed field widths of the ports.
  localparam int OPCODE_W   = 3;
  localparam int ADDR_W     = 32;
  localparam int REG_W      = 17;
  localparam int STATUS_W   = 2;
  localparam int FREE_CNT_W = 17;
  localparam int REF_OUT_W  = 16;
  localparam int CFG_IDX_W  = 1;

  localparam logic [REG_W-1:0] LOW_PAGE_RST = 17'h00000;
  localparam logic [REG_W-1:0] TOP_PAGE_RST = 17'h10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_PAGE = 1'b0,
    CFG_TOP_PAGE = 1'b1
  } cfg_idx_t;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ALLOC = 3'd0,
    OP_FREE  = 3'd1,
    OP_INC   = 3'd2,
    OP_DEC   = 3'd3,
    OP_QUERY = 3'd4
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_PAGES = 2'd1,
    ST_BAD_ADDR = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ALU_PASS = 2'd0,
    ALU_INC  = 2'd1,
    ALU_DEC  = 2'd2,
    ALU_ONE  = 2'd3
  } alu_op_t;

  typedef enum logic [1:0] {
    S_CLEAR = 2'd0,
    S_IDLE  = 2'd1,
    S_EXEC  = 2'd2
  } state_t;

endpackage

`default_nettype wire

FILE: sv/refcounted_page_allocator_unit.sv
// Top level of the reference-counted page allocator: sequencer, stack pointer,
// configuration registers and result register. Depends on rpa_pkg, rpa_alu,
// rpa_count_store and rpa_free_stack.
//
//   Channel  Direction  Handshake           Payload
//   in_      input      in_valid/in_stall   in_opcode, in_byte_address
//   out_     output     out_valid/out_stall out_page_address, out_status,
//                                           out_released, out_free_count,
//                                           out_page_ref_count
//   cfg_     input      cfg_we              cfg_index, cfg_wdata
//
// Each transaction has an accept and an execute step: in the accept cycle
// both memories are read (count at the addressed page, stack at its top
// entry), and in the execute state the shared count unit updates the count,
// the memories are written and the result register is loaded. After reset a
// clearing pass zeroes the count memory, one entry a cycle, for all MAX_PAGES
// entries (65536 by default); input stays stalled meanwhile while
// configuration writes are taken as usual. A result waiting under out_stall
// does not block the next input transaction; only its execute cycle waits
// until the result register is free.
`default_nettype none

module refcounted_page_allocator_unit #(
  parameter int PAGE_SHIFT = rpa_pkg::PAGE_SHIFT_DEF,
  parameter int MAX_PAGES  = rpa_pkg::MAX_PAGES_DEF,
  parameter int COUNT_BITS = rpa_pkg::COUNT_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [rpa_pkg::OPCODE_W-1:0] in_opcode,
  input  wire logic [rpa_pkg::ADDR_W-1:0]  in_byte_address,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [rpa_pkg::ADDR_W-1:0]       out_page_address,
  output logic [rpa_pkg::STATUS_W-1:0]     out_status,
  output logic                             out_released,
  output logic [rpa_pkg::FREE_CNT_W-1:0]   out_free_count,
  output logic [rpa_pkg::REF_OUT_W-1:0]    out_page_ref_count,
  input  wire logic                        cfg_we,
  input  wire logic [rpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rpa_pkg::REG_W-1:0]   cfg_wdata
);
  import rpa_pkg::*;

  // Page index width, stack depth width, and widened views used to slice
  // the fixed-width result fields out of parameter-sized values.
  localparam int PW  = $clog2(MAX_PAGES);
  localparam int DW  = $clog2(MAX_PAGES + 1);
  localparam int FW  = (DW > FREE_CNT_W) ? DW : FREE_CNT_W;
  localparam int CE  = (COUNT_BITS > REF_OUT_W) ? COUNT_BITS : REF_OUT_W;
  localparam int PAW = (PW + PAGE_SHIFT > ADDR_W) ? PW + PAGE_SHIFT : ADDR_W;

  state_t state_r, state_nxt;

  logic [REG_W-1:0]  low_page_r;
  logic [REG_W-1:0]  top_page_r;
  opcode_t           op_r;
  logic [ADDR_W-1:0] addr_r;
  logic [DW-1:0]     depth_r, depth_nxt;

  logic                  out_valid_r;
  logic [ADDR_W-1:0]     page_addr_r, page_addr_nxt;
  status_t               status_r, status_nxt;
  logic                  released_r, released_nxt;
  logic [FREE_CNT_W-1:0] free_cnt_r;
  logic [REF_OUT_W-1:0]  ref_cnt_r, ref_cnt_nxt;

  logic            accept;
  logic            out_free;
  logic            load;
  logic            clr_busy;
  logic [DW-1:0]   depth_dec;

  logic            cnt_we;
  logic [PW-1:0]   cnt_waddr;
  logic [PW-1:0]   cnt_raddr;
  logic [COUNT_BITS-1:0] cnt_q;
  logic            stk_we;
  logic [PW-1:0]   stk_q;

  alu_op_t               alu_op;
  logic [COUNT_BITS-1:0] alu_y;

  logic [ADDR_W-1:0] page_full;
  logic [PW-1:0]     page_idx;
  logic              aligned;
  logic              in_table;
  logic              in_window;
  logic              stack_full;
  logic [PAW-1:0]    page_addr_ext;
  logic [CE-1:0]     ref_ext;
  logic [FW-1:0]     depth_ext;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // Configuration registers; writes are taken in any state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_page_r <= LOW_PAGE_RST;
      top_page_r <= TOP_PAGE_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_LOW_PAGE: low_page_r <= cfg_wdata;
        CFG_TOP_PAGE: top_page_r <= cfg_wdata;
        default:      low_page_r <= low_page_r;
      endcase
    end
  end

  // The transaction is captured at accept; the memories are read in the same cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= opcode_t'(in_opcode);
      addr_r <= in_byte_address;
    end
  end

  assign cnt_raddr = PW'(in_byte_address >> PAGE_SHIFT);
  assign depth_dec = depth_r - DW'(1);

  rpa_count_store #(
    .DEPTH (MAX_PAGES),
    .AW    (PW),
    .CW    (COUNT_BITS)
  ) u_count_store (
    .clk   (clk),
    .rst_n (rst_n),
    .busy  (clr_busy),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (alu_y),
    .re    (accept),
    .raddr (cnt_raddr),
    .rdata (cnt_q)
  );

  // Pushes land at the current depth; the pop reads the entry just below it.
  rpa_free_stack #(
    .DEPTH (MAX_PAGES),
    .AW    (PW)
  ) u_free_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (depth_r[PW-1:0]),
    .wdata (page_idx),
    .re    (accept),
    .raddr (depth_dec[PW-1:0]),
    .rdata (stk_q)
  );

  rpa_alu #(
    .CW (COUNT_BITS)
  ) u_alu (
    .op (alu_op),
    .a  (cnt_q),
    .y  (alu_y)
  );

  // Address checks on the captured transaction.
  assign page_full  = addr_r >> PAGE_SHIFT;
  assign page_idx   = page_full[PW-1:0];
  assign aligned    = (addr_r[PAGE_SHIFT-1:0] == '0);
  assign in_table   = (page_full < ADDR_W'(MAX_PAGES));
  assign in_window  = (page_full >= ADDR_W'(low_page_r)) && (page_full < ADDR_W'(top_page_r));
  assign stack_full = (depth_r == DW'(MAX_PAGES));

  assign page_addr_ext = PAW'(stk_q) << PAGE_SHIFT;
  assign ref_ext       = CE'(alu_y);

  // Sequencer and execute step. Writes and the result load all wait for
  // a free result register so that one transaction commits as a whole.
  always_comb begin
    state_nxt     = state_r;
    load          = 1'b0;
    alu_op        = ALU_PASS;
    cnt_we        = 1'b0;
    cnt_waddr     = page_idx;
    stk_we        = 1'b0;
    depth_nxt     = depth_r;
    page_addr_nxt = '0;
    status_nxt    = ST_OK;
    released_nxt  = 1'b0;
    ref_cnt_nxt   = ref_ext[REF_OUT_W-1:0];

    case (state_r)
      S_CLEAR: begin
        if (!clr_busy) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          load      = 1'b1;
          state_nxt = S_IDLE;
        end
        case (op_r)
          OP_ALLOC: begin
            if (depth_r == '0) begin
              status_nxt  = ST_NO_PAGES;
              ref_cnt_nxt = '0;
            end else begin
              // The popped page gets a count of one.
              alu_op        = ALU_ONE;
              cnt_waddr     = stk_q;
              cnt_we        = load;
              depth_nxt     = depth_dec;
              page_addr_nxt = page_addr_ext[ADDR_W-1:0];
            end
          end
          OP_FREE: begin
            if (!aligned || !in_table || !in_window) begin
              status_nxt  = ST_BAD_ADDR;
              ref_cnt_nxt = '0;
            end else if (cnt_q <= COUNT_BITS'(1)) begin
              // Last reference: pushed back unless the stack is full; count kept.
              if (stack_full) begin
                status_nxt = ST_FULL;
              end else begin
                stk_we       = load;
                depth_nxt    = depth_r + DW'(1);
                released_nxt = 1'b1;
              end
            end else begin
              alu_op = ALU_DEC;
              cnt_we = load;
            end
          end
          OP_INC, OP_DEC: begin
            if (!in_table) begin
              status_nxt  = ST_BAD_ADDR;
              ref_cnt_nxt = '0;
            end else begin
              alu_op = (op_r == OP_INC) ? ALU_INC : ALU_DEC;
              cnt_we = load;
            end
          end
          default: begin
            // Query, and the unused opcodes that behave as query.
            if (!in_table) begin
              status_nxt  = ST_BAD_ADDR;
              ref_cnt_nxt = '0;
            end
          end
        endcase
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  assign depth_ext = FW'(depth_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        depth_r     <= depth_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      page_addr_r <= page_addr_nxt;
      status_r    <= status_nxt;
      released_r  <= released_nxt;
      free_cnt_r  <= depth_ext[FREE_CNT_W-1:0];
      ref_cnt_r   <= ref_cnt_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_page_address   = page_addr_r;
  assign out_status         = status_r;
  assign out_released       = released_r;
  assign out_free_count     = free_cnt_r;
  assign out_page_ref_count = ref_cnt_r;

endmodule

`default_nettype wire

FILE: sv/rpa_alu.sv
// Shared count unit: saturating increment and decrement, load of one, pass.
// Depends on rpa_pkg for the operation codes.
`default_nettype none

module rpa_alu #(
  parameter int CW = rpa_pkg::COUNT_BITS_DEF
) (
  input  wire rpa_pkg::alu_op_t op,
  input  wire logic [CW-1:0]    a,
  output logic [CW-1:0]         y
);
  import rpa_pkg::*;

  localparam logic [CW-1:0] CNT_MAX = '1;

  always_comb begin
    case (op)
      ALU_INC:  y = (a == CNT_MAX) ? a : a + CW'(1);
      ALU_DEC:  y = (a == '0) ? a : a - CW'(1);
      ALU_ONE:  y = CW'(1);
      default:  y = a;
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/rpa_count_store.sv
// Reference count memory with one write and one registered read port, plus the
// clearing sweep that zeroes every entry after reset. Depends on rpa_pkg.
`default_nettype none

module rpa_count_store #(
  parameter int DEPTH = rpa_pkg::MAX_PAGES_DEF,
  parameter int AW    = $clog2(rpa_pkg::MAX_PAGES_DEF),
  parameter int CW    = rpa_pkg::COUNT_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  output logic               busy,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [CW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic [CW-1:0]      rdata
);
  import rpa_pkg::*;

  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [CW-1:0] mem [DEPTH];
  logic          busy_r;
  logic [AW-1:0] clr_addr_r;
  logic [CW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b1;
      clr_addr_r <= '0;
    end else if (busy_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == LAST) begin
        busy_r <= 1'b0;
      end
    end
  end

  // The sweep owns the write port while it runs.
  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign busy  = busy_r;
  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: sv/rpa_free_stack.sv
// Free page stack memory: one write port, one registered read port.
// Contents are undefined until pushed. Depends on rpa_pkg.
`default_nettype none

module rpa_free_stack #(
  parameter int DEPTH = rpa_pkg::MAX_PAGES_DEF,
  parameter int AW    = $clog2(rpa_pkg::MAX_PAGES_DEF)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [AW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic [AW-1:0]      rdata
);
  import rpa_pkg::*;

  logic [AW-1:0] mem [DEPTH];
  logic [AW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: sv/rpa_checker.sv
// Port-level checks for the page allocator, attached to the top level by bind.
// Depends on rpa_pkg for field widths and status codes.
`default_nettype none

module rpa_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_stall,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic [rpa_pkg::ADDR_W-1:0]     out_page_address,
  input wire logic [rpa_pkg::STATUS_W-1:0]   out_status,
  input wire logic                           out_released,
  input wire logic [rpa_pkg::FREE_CNT_W-1:0] out_free_count,
  input wire logic [rpa_pkg::REF_OUT_W-1:0]  out_page_ref_count
);
  import rpa_pkg::*;

  // No result is presented in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A transaction keeps the input stalled for its execute cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted back to back");

  // Failed allocations and bad addresses report no page and no count.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_NO_PAGES || out_status == ST_BAD_ADDR)
    |-> out_page_address == '0 && out_page_ref_count == '0)
    else $error("failed transaction reports page or count");

  // A release comes only from a successful free, which never names a page.
  a_release_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_released |-> out_status == ST_OK && out_page_address == '0
    && out_page_ref_count <= REF_OUT_W'(1))
    else $error("release on a failed or non-free transaction");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_page_address)
    && $stable(out_status) && $stable(out_released) && $stable(out_free_count)
    && $stable(out_page_ref_count))
    else $error("stalled result changed");

endmodule

bind refcounted_page_allocator_unit rpa_checker u_rpa_checker (.*);

`default_nettype wire
